[rtl/rpt_pkg.sv]
// Shared constants and widths for the rotary position table value unit.
// Depends on nothing; every rtl file imports it.
`default_nettype none
package rpt_pkg;

  // Register indexes (decoded from paddr[2])
  localparam logic REG_HEAD_WIDTH = 1'b0;
  localparam logic REG_THETA_LOG2 = 1'b1;

  // Field widths
  localparam int unsigned POS_W   = 12;
  localparam int unsigned PAIR_W  = 7;
  localparam int unsigned HD_W    = 9;
  localparam int unsigned THETA_W = 24;
  localparam int unsigned VAL_W   = 16;

  // Datapath widths
  localparam int unsigned NUM_W  = 48;  // dividend of the exponent division
  localparam int unsigned TERM_W = 33;  // series term, Q.30
  localparam int unsigned OP_W   = 32;  // series multiplicand, Q.30
  localparam int unsigned SUM_W  = 36;  // signed series sum, Q.30
  localparam int unsigned PH_W   = 44;  // phase before reduction, Q.30
  localparam int unsigned SHF_W  = 6;   // saturated shift count

  // Shift counts at or above this give a zero phase
  localparam logic [SHF_W-1:0] SHF_SAT = 6'd44;

  // Q.30 constants
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF    = 64'd536870912;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

endpackage
`default_nettype wire

[rtl/rpt_div.sv]
// Pipelined restoring divider: NUM_W-bit dividend by a narrow divisor,
// eight quotient bits per stage. Depends on rpt_pkg.
`default_nettype none
module rpt_div #(
  parameter int unsigned DIV_W  = 9,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [rpt_pkg::NUM_W-1:0] num_i,
  input  logic [DIV_W-1:0]          den_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [rpt_pkg::NUM_W-1:0] quot_o,
  output logic [SIDE_W-1:0]         side_o
);
  import rpt_pkg::*;

  localparam int unsigned BITS   = 8;
  localparam int unsigned STAGES = NUM_W / BITS;

  logic              v_q    [STAGES+1];
  logic [NUM_W-1:0]  w_q    [STAGES+1];
  logic [DIV_W-1:0]  rem_q  [STAGES+1];
  logic [SIDE_W-1:0] side_q [STAGES+1];

  assign v_q[0]    = valid_i;
  assign w_q[0]    = num_i;
  assign rem_q[0]  = '0;
  assign side_q[0] = side_i;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [NUM_W-1:0] w_d;
    logic [DIV_W-1:0] rem_d;

    // shift a dividend bit into the remainder, a quotient bit into the word
    always_comb begin
      logic [DIV_W:0] part;
      logic           ge;
      w_d   = w_q[g];
      rem_d = rem_q[g];
      for (int b = 0; b < BITS; b++) begin
        part  = {rem_d, w_d[NUM_W-1]};
        ge    = part >= {1'b0, den_i};
        if (ge) begin
          part = part - {1'b0, den_i};
        end
        rem_d = part[DIV_W-1:0];
        w_d   = {w_d[NUM_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else if (en_i) begin
        v_q[g+1] <= v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q[g+1]    <= w_d;
        rem_q[g+1]  <= rem_d;
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign valid_o = v_q[STAGES];
  assign quot_o  = w_q[STAGES];
  assign side_o  = side_q[STAGES];

endmodule
`default_nettype wire

[rtl/rpt_series_step.sv]
// One term of a Taylor series: Q.30 multiply, then exact divide by a
// constant through a reciprocal, then accumulate. Depends on rpt_pkg.
`default_nettype none
module rpt_series_step #(
  parameter int unsigned K      = 1,
  parameter bit          NEG    = 1'b0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [rpt_pkg::TERM_W-1:0]       term_i,
  input  logic [rpt_pkg::OP_W-1:0]         op_i,
  input  logic signed [rpt_pkg::SUM_W-1:0] sum_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic [rpt_pkg::TERM_W-1:0]       term_o,
  output logic [rpt_pkg::OP_W-1:0]         op_o,
  output logic signed [rpt_pkg::SUM_W-1:0] sum_o,
  output logic [SIDE_W-1:0]                side_o
);
  import rpt_pkg::*;

  localparam int unsigned L      = $clog2(K);
  localparam int unsigned S      = TERM_W + L;
  localparam int unsigned RECIPW = TERM_W + 1;
  localparam longint unsigned RECIP = ((64'd1 << S) + 64'(K) - 64'd1) / 64'(K);
  localparam int unsigned PRODW  = TERM_W + OP_W;
  localparam int unsigned QW     = S + TERM_W;

  logic                     a_v_q;
  logic [TERM_W-1:0]        a_prod_q;
  logic [OP_W-1:0]          a_op_q;
  logic signed [SUM_W-1:0]  a_sum_q;
  logic [SIDE_W-1:0]        a_side_q;

  logic [PRODW-1:0]         prod;
  logic [PRODW-1:0]         prod_rnd;
  logic [QW-1:0]            quo_full;
  logic [TERM_W-1:0]        quo;
  logic signed [SUM_W-1:0]  quo_s;

  // term * op, rounded half up to Q.30
  assign prod     = PRODW'(term_i) * PRODW'(op_i);
  assign prod_rnd = prod + PRODW'(Q30_HALF);

  // floor divide by K: multiply by the rounded-up reciprocal, drop S bits
  assign quo_full = QW'(a_prod_q) * QW'(RECIPW'(RECIP));
  assign quo      = quo_full[S +: TERM_W];
  assign quo_s    = $signed(SUM_W'(quo));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      a_v_q   <= valid_i;
      valid_o <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_prod_q <= prod_rnd[30 +: TERM_W];
      a_op_q   <= op_i;
      a_sum_q  <= sum_i;
      a_side_q <= side_i;
      term_o   <= quo;
      op_o     <= a_op_q;
      sum_o    <= NEG ? (a_sum_q - quo_s) : (a_sum_q + quo_s);
      side_o   <= a_side_q;
    end
  end

endmodule
`default_nettype wire

[rtl/rotary_position_table_value_unit.sv]
// Rotary position table value unit: top level with config registers and pipeline.
// Depends on rpt_pkg, rpt_div and rpt_series_step.
`default_nettype none
// Each input word carries a frame position, a rotary pair index and a sine or
// cosine select; each output word carries one signed Q1.15 table value,
// cos/sin(position * theta^(-2*pair/head width)), with +1 saturated to 32767.
// The pipeline takes one word per clock while it is not held: one input stage
// with the pair*theta product, six stages of the exponent divider (eight
// quotient bits each), one stage for the ln2 scaling, thirty-two stages for
// the sixteen exp terms (multiply, then reciprocal divide), two for the phase
// product and its rounding shift, three for the reduction modulo two pi, one
// quadrant fold, one square, sixteen for the eight sine terms and the output
// register. The whole pipeline holds while a finished word waits at the output
// and the sink is not ready; bubbles travel with their valid bits.
// Configuration (head width at address 0, theta_log2 at 4) is to be written by
// the user only while the unit is drained; the unit does not enforce this. The
// head width is clamped to 2..MAX_HEAD_DIM and the position to MAX_FRAMES-1.
module rotary_position_table_value_unit #(
  parameter int unsigned MAX_FRAMES   = 4096,
  parameter int unsigned MAX_HEAD_DIM = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] position, [18:12] pair_index, zero pad
  input  logic        s_axis_tuser,   // [0] mode
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] table_value
);
  import rpt_pkg::*;

  localparam int unsigned DIV_W   = $clog2(MAX_HEAD_DIM + 1);
  localparam int unsigned EXP_N   = 16;
  localparam int unsigned SIN_N   = 8;
  localparam int unsigned EXP_SW  = SHF_W + 1 + POS_W;
  localparam int unsigned MOD_ST  = 3;
  localparam int unsigned MOD_BITS = 11;

  // ---------------------------------------------------------------- config
  logic [HD_W-1:0]    head_width_q;
  logic [THETA_W-1:0] theta_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_width_q <= 9'd64;
      theta_q      <= 24'd870823;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_HEAD_WIDTH: head_width_q <= pwdata[HD_W-1:0];
        REG_THETA_LOG2: theta_q      <= pwdata[THETA_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HEAD_WIDTH: prdata = 32'(head_width_q);
      REG_THETA_LOG2: prdata = 32'(theta_q);
      default:        prdata = '0;
    endcase
  end

  // clamp the divisor into 2..MAX_HEAD_DIM
  logic [DIV_W-1:0] hd_eff;
  always_comb begin
    if (32'(head_width_q) < 32'd2) begin
      hd_eff = DIV_W'(2);
    end else if (32'(head_width_q) > 32'(MAX_HEAD_DIM)) begin
      hd_eff = DIV_W'(MAX_HEAD_DIM);
    end else begin
      hd_eff = DIV_W'(head_width_q);
    end
  end

  // ------------------------------------------------------------ stall rule
  logic out_v_q;
  logic en;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // --------------------------------------------------- input stage: product
  logic              s0_v_q;
  logic [NUM_W-1:0]  s0_num_q;
  logic [POS_W-1:0]  s0_t_q;
  logic              s0_mode_q;
  logic [POS_W-1:0]  t_clamp;
  logic [30:0]       pt_prod;

  assign t_clamp = (32'(s_axis_tdata[11:0]) >= 32'(MAX_FRAMES)) ?
                   POS_W'(MAX_FRAMES - 1) : s_axis_tdata[11:0];
  assign pt_prod = 31'(s_axis_tdata[18:12]) * 31'(theta_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // (2 * pair * theta) << 14
      s0_num_q  <= {2'b00, pt_prod, 15'd0};
      s0_t_q    <= t_clamp;
      s0_mode_q <= s_axis_tuser;
    end
  end

  // ---------------------------------------- exponent x = num / head width
  logic              dv_v;
  logic [NUM_W-1:0]  dv_x;
  logic [POS_W:0]    dv_side;

  rpt_div #(
    .DIV_W  (DIV_W),
    .SIDE_W (POS_W + 1)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_v_q),
    .num_i   (s0_num_q),
    .den_i   (hd_eff),
    .side_i  ({s0_mode_q, s0_t_q}),
    .valid_o (dv_v),
    .quot_o  (dv_x),
    .side_o  (dv_side)
  );

  // ---------------------------- split x: y = frac * ln2, saturated shift n
  logic              y_v_q;
  logic [29:0]       y_q;
  logic [EXP_SW-1:0] y_side_q;
  logic [59:0]       y_prod;
  logic [SHF_W-1:0]  n_sat;

  assign y_prod = 60'(dv_x[29:0]) * 60'(LN2_Q30) + 60'(Q30_HALF);
  assign n_sat  = (dv_x[NUM_W-1:30] >= 18'(SHF_SAT)) ? SHF_SAT : dv_x[35:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_v_q <= 1'b0;
    end else if (en) begin
      y_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_q      <= y_prod[59:30];
      y_side_q <= {n_sat, dv_side};
    end
  end

  // ------------------------------------------------- exp(-y), 16 terms
  logic                    ex_v    [EXP_N+1];
  logic [TERM_W-1:0]       ex_term [EXP_N+1];
  logic [OP_W-1:0]         ex_op   [EXP_N+1];
  logic signed [SUM_W-1:0] ex_sum  [EXP_N+1];
  logic [EXP_SW-1:0]       ex_side [EXP_N+1];

  assign ex_v[0]    = y_v_q;
  assign ex_term[0] = TERM_W'(Q30_ONE);
  assign ex_op[0]   = OP_W'(y_q);
  assign ex_sum[0]  = $signed(SUM_W'(Q30_ONE));
  assign ex_side[0] = y_side_q;

  for (genvar g = 0; g < EXP_N; g++) begin : g_exp
    rpt_series_step #(
      .K      (g + 1),
      .NEG    ((g % 2) == 0),
      .SIDE_W (EXP_SW)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (ex_v[g]),
      .term_i  (ex_term[g]),
      .op_i    (ex_op[g]),
      .sum_i   (ex_sum[g]),
      .side_i  (ex_side[g]),
      .valid_o (ex_v[g+1]),
      .term_o  (ex_term[g+1]),
      .op_o    (ex_op[g+1]),
      .sum_o   (ex_sum[g+1]),
      .side_o  (ex_side[g+1])
    );
  end

  // --------------------------------------------- phase = t * mant >> n
  logic              p1_v_q;
  logic [PH_W-2:0]   p1_prod_q;
  logic [SHF_W-1:0]  p1_n_q;
  logic              p1_mode_q;
  logic [30:0]       mant;
  logic [EXP_SW-1:0] ex_out_side;

  assign ex_out_side = ex_side[EXP_N];
  // clamp the series at zero from below
  assign mant = ex_sum[EXP_N][SUM_W-1] ? '0 : ex_sum[EXP_N][30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= ex_v[EXP_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_prod_q <= (PH_W - 1)'(ex_out_side[POS_W-1:0]) * (PH_W - 1)'(mant);
      p1_mode_q <= ex_out_side[POS_W];
      p1_n_q    <= ex_out_side[EXP_SW-1 -: SHF_W];
    end
  end

  // rounding shift, half up
  logic [PH_W-1:0] ph_rnd;
  logic [PH_W-1:0] ph_sum;
  logic [PH_W-1:0] ph_d;

  assign ph_rnd = (p1_n_q == '0) ? '0 : (PH_W'(1) << (p1_n_q - SHF_W'(1)));
  assign ph_sum = PH_W'(p1_prod_q) + ph_rnd;
  assign ph_d   = (p1_n_q >= SHF_SAT) ? '0 : (ph_sum >> p1_n_q);

  // ------------------------------------------- reduce modulo two pi
  logic            md_v    [MOD_ST+1];
  logic [PH_W-1:0] md_r    [MOD_ST+1];
  logic            md_mode [MOD_ST+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_v[0] <= 1'b0;
    end else if (en) begin
      md_v[0] <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_r[0]    <= ph_d;
      md_mode[0] <= p1_mode_q;
    end
  end

  // subtract two pi shifted by 10 down to 0, four shifts per stage, three in the last
  for (genvar g = 0; g < MOD_ST; g++) begin : g_mod
    localparam int HI = MOD_BITS - 1 - 4 * g;
    localparam int LO = (HI - 3 < 0) ? 0 : HI - 3;
    logic [PH_W-1:0] r_d;

    always_comb begin
      r_d = md_r[g];
      for (int b = HI; b >= LO; b--) begin
        if (r_d >= (PH_W'(TWO_PI_Q30) << b)) begin
          r_d = r_d - (PH_W'(TWO_PI_Q30) << b);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        md_v[g+1] <= 1'b0;
      end else if (en) begin
        md_v[g+1] <= md_v[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        md_r[g+1]    <= r_d;
        md_mode[g+1] <= md_mode[g];
      end
    end
  end

  // --------------------------------- cosine shift and quadrant fold
  logic        qd_v_q;
  logic [30:0] qd_r_q;
  logic        qd_neg_q;
  logic [33:0] fold_r;
  logic        fold_neg;

  always_comb begin
    fold_r   = 34'(md_r[MOD_ST]);
    fold_neg = 1'b0;
    if (md_mode[MOD_ST]) begin
      fold_r = fold_r + 34'(HALF_PI_Q30);
      if (fold_r >= 34'(TWO_PI_Q30)) begin
        fold_r = fold_r - 34'(TWO_PI_Q30);
      end
    end
    if (fold_r >= 34'(PI_Q30)) begin
      fold_neg = 1'b1;
      fold_r   = fold_r - 34'(PI_Q30);
    end
    if (fold_r > 34'(HALF_PI_Q30)) begin
      fold_r = 34'(PI_Q30) - fold_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qd_v_q <= 1'b0;
    end else if (en) begin
      qd_v_q <= md_v[MOD_ST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qd_r_q   <= fold_r[30:0];
      qd_neg_q <= fold_neg;
    end
  end

  // ------------------------------------------------------- square of r
  logic              sq_v_q;
  logic [30:0]       sq_r_q;
  logic [OP_W-1:0]   sq_r2_q;
  logic              sq_neg_q;
  logic [61:0]       sq_prod;

  assign sq_prod = 62'(qd_r_q) * 62'(qd_r_q) + 62'(Q30_HALF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
    end else if (en) begin
      sq_v_q <= qd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_r_q   <= qd_r_q;
      sq_r2_q  <= sq_prod[30 +: OP_W];
      sq_neg_q <= qd_neg_q;
    end
  end

  // ----------------------------------------- sine series through r^17
  logic                    sn_v    [SIN_N+1];
  logic [TERM_W-1:0]       sn_term [SIN_N+1];
  logic [OP_W-1:0]         sn_op   [SIN_N+1];
  logic signed [SUM_W-1:0] sn_sum  [SIN_N+1];
  logic                    sn_side [SIN_N+1];

  assign sn_v[0]    = sq_v_q;
  assign sn_term[0] = TERM_W'(sq_r_q);
  assign sn_op[0]   = sq_r2_q;
  assign sn_sum[0]  = $signed(SUM_W'(sq_r_q));
  assign sn_side[0] = sq_neg_q;

  for (genvar g = 0; g < SIN_N; g++) begin : g_sin
    rpt_series_step #(
      .K      ((2 * g + 3) * (2 * g + 2)),
      .NEG    ((g % 2) == 0),
      .SIDE_W (1)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sn_v[g]),
      .term_i  (sn_term[g]),
      .op_i    (sn_op[g]),
      .sum_i   (sn_sum[g]),
      .side_i  (sn_side[g]),
      .valid_o (sn_v[g+1]),
      .term_o  (sn_term[g+1]),
      .op_o    (sn_op[g+1]),
      .sum_o   (sn_sum[g+1]),
      .side_o  (sn_side[g+1])
    );
  end

  // -------------------------------------- round to Q1.15, saturate, sign
  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  mag_rnd;
  logic [VAL_W-1:0]  q_sat;
  logic [VAL_W-1:0]  out_d;
  logic [VAL_W-1:0]  out_q;

  assign mag     = sn_sum[SIN_N][SUM_W-1] ? '0 : SUM_W'(sn_sum[SIN_N]);
  assign mag_rnd = (mag + SUM_W'(1 << 14)) >> 15;
  assign q_sat   = (mag_rnd > SUM_W'(32767)) ? VAL_W'(32767) : mag_rnd[VAL_W-1:0];
  assign out_d   = sn_side[SIN_N] ? (VAL_W'(0) - q_sat) : q_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= sn_v[SIN_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

[sim/rotary_position_table_value_unit_test.sv]
// Self-checking bench for the rotary position table value unit.
// Drives stream words and APB writes, predicts each table value in Q.30 integer steps.
// Depends on rpt_pkg and rotary_position_table_value_unit.
`default_nettype none
module rotary_position_table_value_unit_test;
  import rpt_pkg::*;

  localparam int unsigned HEAD_MAX = 256;
  localparam int unsigned LATENCY  = 64;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [11:0] position, [18:12] pair_index, zero pad
  logic        s_axis_tuser = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] table_value

  rotary_position_table_value_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration registers
  logic [8:0]  cfg_head_width = 9'd64;
  logic [23:0] cfg_theta      = 24'd870823;

  logic [15:0] table_queue[$];
  int          fail_count = 0;
  longint unsigned cycle_count = 0;
  bit          long_stall_mode = 0;

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  function automatic logic [15:0] rope_value(logic [11:0] pos, logic [6:0] pair, logic cosine);
    longint unsigned hd, x, n, f, y, term, mant, ph, r, r2, mag, q;
    longint signed   sum;
    bit neg;
    hd = cfg_head_width;
    if (hd < 2) hd = 2;
    if (hd > HEAD_MAX) hd = HEAD_MAX;
    x = ((64'd2 * pair * cfg_theta) << 14) / hd;
    n = x >> 30;
    f = x & 64'h3FFF_FFFF;
    // exp(-f*ln2) by series to order sixteen
    y = q30_mul(f, 64'd744261118);
    term = 64'd1073741824;
    sum = 64'sd1073741824;
    for (int k = 1; k <= 16; k++) begin
      term = q30_mul(term, y) / k;
      if (k % 2) sum -= longint'(term);
      else       sum += longint'(term);
    end
    mant = (sum < 0) ? 0 : longint'(sum);
    if (n >= 63)      ph = 0;
    else if (n == 0)  ph = pos * mant;
    else              ph = (pos * mant + (64'd1 << (n - 1))) >> n;
    r = ph % 64'd6746518852;
    if (cosine) begin
      r += 64'd1686629713;
      if (r >= 64'd6746518852) r -= 64'd6746518852;
    end
    neg = 0;
    if (r >= 64'd3373259426) begin
      neg = 1;
      r -= 64'd3373259426;
    end
    if (r > 64'd1686629713) r = 64'd3373259426 - r;
    // sine in the first quadrant through the seventeenth power
    r2 = q30_mul(r, r);
    term = r;
    sum = longint'(r);
    for (int k = 3; k <= 17; k += 2) begin
      term = q30_mul(term, r2) / (k * (k - 1));
      if (((k - 1) / 2) % 2) sum -= longint'(term);
      else                   sum += longint'(term);
    end
    mag = (sum < 0) ? 0 : longint'(sum);
    q = (mag + 64'd16384) >> 15;
    if (q > 32767) q = 32767;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // Guard the run with a timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Check each returned word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (table_queue.size() == 0) begin
        report_mismatch("table value with nothing pending");
      end else begin
        logic [15:0] want;
        want = table_queue.pop_front();
        if (m_axis_tdata !== want)
          report_mismatch($sformatf("table_value got %0d want %0d",
                                    $signed(m_axis_tdata), $signed(want)));
      end
    end
  end

  // Sink readiness: random stalls, with stretches held ready
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      n = long_stall_mode ? gap_len() * 3 + 1 : $urandom_range(1, 30);
      repeat (n) @(negedge clk_i);
      n = gap_len();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  task automatic send_word(logic [11:0] pos, logic [6:0] pair, logic cosine);
    int n;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, pair, pos};
    s_axis_tuser  <= cosine;
    do @(posedge clk_i); while (!s_axis_tready);
    table_queue.push_back(rope_value(pos, pair, cosine));
    @(negedge clk_i);
    if ($urandom_range(0, 2) == 0) begin
      n = gap_len();
      if (n > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (table_queue.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_HEAD_WIDTH) cfg_head_width = value[8:0];
    else                       cfg_theta      = value[23:0];
  endtask

  task automatic test_directed();
    send_word(12'd0, 7'd0, 1'b1);       // cosine of zero saturates
    send_word(12'd0, 7'd0, 1'b0);
    send_word(12'd4095, 7'd0, 1'b0);
    send_word(12'd4095, 7'd0, 1'b1);
    send_word(12'd4095, 7'd127, 1'b0);  // pair beyond head width
    send_word(12'd4095, 7'd127, 1'b1);
    send_word(12'd1, 7'd31, 1'b1);
    send_word(12'd2048, 7'd16, 1'b0);
    send_word(12'd3, 7'd1, 1'b0);
    send_word(12'd100, 7'd85, 1'b1);
    drain_pipe();
  endtask

  task automatic test_head_width_edges();
    logic [8:0] dims[6] = '{9'd0, 9'd1, 9'd2, 9'd7, 9'd256, 9'd511};
    foreach (dims[d]) begin
      write_reg(REG_HEAD_WIDTH, {23'd0, dims[d]});
      send_word(12'd4095, 7'd0, 1'b0);
      send_word(12'd1234, 7'd1, 1'b1);
      send_word(12'd4095, 7'd127, 1'b0);
      drain_pipe();
    end
  endtask

  task automatic test_random(int count);
    logic [8:0] hd;
    for (int i = 0; i < count; i++) begin
      hd = (cfg_head_width < 2) ? 9'd2 : cfg_head_width;
      if ($urandom_range(0, 9) == 0)
        send_word(12'($urandom), 7'($urandom), 1'($urandom));
      else
        send_word(12'($urandom), 7'($urandom_range(0, (hd / 2 > 0) ? hd / 2 - 1 : 0)),
                  1'($urandom));
      if (i == count / 2) drain_pipe();   // hold the sender until all results land
    end
    drain_pipe();
  endtask

  task automatic test_settings();
    write_reg(REG_THETA_LOG2, 32'd0);
    write_reg(REG_HEAD_WIDTH, 32'd64);
    test_random(60);
    write_reg(REG_THETA_LOG2, 32'hFFFFFF);
    test_random(150);
    write_reg(REG_HEAD_WIDTH, 32'd2);
    write_reg(REG_THETA_LOG2, 32'd65536);
    test_random(150);
    write_reg(REG_HEAD_WIDTH, 32'd256);
    write_reg(REG_THETA_LOG2, 32'd870823);
    long_stall_mode = 1;
    test_random(250);
    long_stall_mode = 0;
    for (int s = 0; s < 5; s++) begin
      write_reg(REG_HEAD_WIDTH, 32'($urandom_range(0, 511)));
      write_reg(REG_THETA_LOG2, 32'($urandom) & 32'hFFFFFF);
      test_random(160);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_head_width_edges();
    test_settings();
    if (fail_count == 0) $display("Regression PASS");
    else                 $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
rtl/rpt_pkg.sv
rtl/rpt_div.sv
rtl/rpt_series_step.sv
rtl/rotary_position_table_value_unit.sv
sim/rotary_position_table_value_unit_test.sv
